>>> src/tpsbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsbl_pkg
// Shared types and constants for the two-wire byte link device side.
// ----------------------------------------------------------------------------
package tpsbl_pkg;

   localparam int unsigned OpWidth    = 2;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned DelayWidth = 10;
   localparam int unsigned CountWidth = 4;

   localparam logic [DelayWidth-1:0] DelayReset   = 10'd10;
   localparam logic [CountWidth-1:0] BitsPerByte  = 4'd8;
   localparam logic [ByteWidth-1:0]  MsbMask      = 8'h80;

   // operation codes; the spare code acts as a plain tick
   localparam logic [OpWidth-1:0] OpTick  = 2'd0;
   localparam logic [OpWidth-1:0] OpRecv  = 2'd1;
   localparam logic [OpWidth-1:0] OpSend  = 2'd2;
   localparam logic [OpWidth-1:0] OpSpare = 2'd3;

   // one sampled tick from the input channel
   typedef struct packed {
      logic [OpWidth-1:0]   operation;
      logic [ByteWidth-1:0] tx_byte;
      logic                 write_level;
      logic                 sense_level;
      logic                 motor_on;
   } request_type;

   // one result item
   typedef struct packed {
      logic                 sense_drive;
      logic                 rx_valid;
      logic [ByteWidth-1:0] rx_byte;
      logic                 tx_done;
      logic                 aborted;
      logic                 busy_res;
   } result_type;

endpackage

>>> src/tape_port_serial_byte_link.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_port_serial_byte_link
// Device side of a two-wire byte link: one sampled line tick per item,
// receive and send of single bytes, motor abort, configurable busy delay.
//
//   channel  direction  handshake        payload
//   req_     in         valid / stall    operation, tx_byte, line levels
//   rsp_     out        valid / stall    sense_drive, rx, tx, abort, busy
//   csr_     in         valid / ready    busy_delay_ticks (10 bits)
//
// One item per cycle while req_stall is low; each result is formed combinationally
// by the sequencer and registered in the output register, or in the skid stage while rsp_stall holds it.
// Reset is synchronous; it clears the sequencer and the busy delay to 10.
// A stalled result is held in the output register, one more in a skid stage;
// req_stall rises only when both are full. csr_ready is always high.
// ----------------------------------------------------------------------------
module tape_port_serial_byte_link (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tpsbl_pkg::OpWidth-1:0]    req_operation,
   input  logic [tpsbl_pkg::ByteWidth-1:0]  req_tx_byte,
   input  logic                             req_write_level,
   input  logic                             req_sense_level,
   input  logic                             req_motor_on,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_sense_drive,
   output logic                             rsp_rx_valid,
   output logic [tpsbl_pkg::ByteWidth-1:0]  rsp_rx_byte,
   output logic                             rsp_tx_done,
   output logic                             rsp_aborted,
   output logic                             rsp_busy_res,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tpsbl_pkg::DelayWidth-1:0] csr_data
);

   tpsbl_pkg::request_type req;
   tpsbl_pkg::result_type  step_result;
   tpsbl_pkg::result_type  out_ff;
   tpsbl_pkg::result_type  skid_ff;
   logic                   out_vld_ff;
   logic                   skid_vld_ff;
   logic                   accept;
   logic                   drain;

   assign req_stall = skid_vld_ff;
   assign accept    = req_valid && !req_stall;
   assign drain     = !out_vld_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign req.operation   = req_operation;
   assign req.tx_byte     = req_tx_byte;
   assign req.write_level = req_write_level;
   assign req.sense_level = req_sense_level;
   assign req.motor_on    = req_motor_on;

   // sequencer
   tpsbl_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req),
      .cfg_write (csr_valid && csr_ready),
      .cfg_data  (csr_data),
      .result    (step_result)
   );

   // output register and skid stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (drain) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= accept;
         end else begin
            out_vld_ff  <= accept;
         end
      end else if (accept) begin
         skid_vld_ff <= 1'b1;
      end
   end

   // output register and skid stage payload
   always_ff @(posedge clock) begin
      if (drain) begin
         if (skid_vld_ff) begin
            out_ff <= skid_ff;
            if (accept) begin
               skid_ff <= step_result;
            end
         end else if (accept) begin
            out_ff <= step_result;
         end
      end else if (accept) begin
         skid_ff <= step_result;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_sense_drive = out_ff.sense_drive;
   assign rsp_rx_valid    = out_ff.rx_valid;
   assign rsp_rx_byte     = out_ff.rx_byte;
   assign rsp_tx_done     = out_ff.tx_done;
   assign rsp_aborted     = out_ff.aborted;
   assign rsp_busy_res    = out_ff.busy_res;

endmodule

>>> src/tpsbl_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsbl_fsm
// Link sequencer: advances one tick per accepted item and forms its result.
// ----------------------------------------------------------------------------
module tpsbl_fsm (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  tpsbl_pkg::request_type           req,
   input  logic                             cfg_write,
   input  logic [tpsbl_pkg::DelayWidth-1:0] cfg_data,
   output tpsbl_pkg::result_type            result
);

   // phase codes
   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_RX_HIGH  = 4'd1;
   localparam logic [3:0] PH_RX_LOW   = 4'd2;
   localparam logic [3:0] PH_RX_UP    = 4'd3;
   localparam logic [3:0] PH_RX_DOWN  = 4'd4;
   localparam logic [3:0] PH_RX_DELAY = 4'd5;
   localparam logic [3:0] PH_TX_START = 4'd6;
   localparam logic [3:0] PH_TX_FALL  = 4'd7;
   localparam logic [3:0] PH_TX_RISE  = 4'd8;
   localparam logic [3:0] PH_TX_END   = 4'd9;

   logic [3:0]                       phase_ff, phase_in;
   logic [tpsbl_pkg::CountWidth-1:0] bit_count_ff, bit_count_in;
   logic [tpsbl_pkg::ByteWidth-1:0]  shift_ff, shift_in;
   logic [tpsbl_pkg::DelayWidth-1:0] delay_count_ff, delay_count_in;
   logic                             sense_ff, sense_in;
   logic [tpsbl_pkg::DelayWidth-1:0] busy_delay_ff;

   logic all_bits;

   assign all_bits = (bit_count_ff >= tpsbl_pkg::BitsPerByte);

   // next state and result for the current tick
   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      delay_count_in = delay_count_ff;
      sense_in       = sense_ff;
      result         = '0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (req.operation == tpsbl_pkg::OpRecv) begin
               sense_in     = 1'b1;
               shift_in     = '0;
               bit_count_in = '0;
               phase_in     = PH_RX_HIGH;
            end else if (req.operation == tpsbl_pkg::OpSend) begin
               sense_in     = 1'b1;
               shift_in     = req.tx_byte;
               bit_count_in = '0;
               phase_in     = PH_TX_START;
            end
         end
         PH_RX_HIGH: begin
            if (req.motor_on) begin
               result.aborted = 1'b1;
               phase_in       = PH_IDLE;
            end else if (req.write_level) begin
               shift_in     = {shift_ff[tpsbl_pkg::ByteWidth-2:0], req.sense_level};
               bit_count_in = bit_count_ff + 1'b1;
               phase_in     = PH_RX_LOW;
            end
         end
         PH_RX_LOW: begin
            if (req.motor_on) begin
               result.aborted = 1'b1;
               phase_in       = PH_IDLE;
            end else if (!req.write_level) begin
               phase_in = all_bits ? PH_RX_UP : PH_RX_HIGH;
            end
         end
         PH_RX_UP: begin
            if (req.motor_on) begin
               result.aborted = 1'b1;
               phase_in       = PH_IDLE;
            end else if (req.sense_level) begin
               phase_in = PH_RX_DOWN;
            end
         end
         PH_RX_DOWN: begin
            if (req.motor_on) begin
               result.aborted = 1'b1;
               phase_in       = PH_IDLE;
            end else if (!req.sense_level) begin
               if (busy_delay_ff == '0) begin
                  sense_in        = 1'b0;
                  result.rx_valid = 1'b1;
                  result.rx_byte  = shift_ff;
                  phase_in        = PH_IDLE;
               end else begin
                  delay_count_in = busy_delay_ff;
                  phase_in       = PH_RX_DELAY;
               end
            end
         end
         PH_RX_DELAY: begin
            // motor is ignored while the busy delay runs
            if (delay_count_ff <= 1) begin
               delay_count_in  = '0;
               sense_in        = 1'b0;
               result.rx_valid = 1'b1;
               result.rx_byte  = shift_ff;
               phase_in        = PH_IDLE;
            end else begin
               delay_count_in = delay_count_ff - 1'b1;
            end
         end
         PH_TX_START: begin
            if (req.motor_on) begin
               result.aborted = 1'b1;
               result.tx_done = 1'b1;
               phase_in       = PH_IDLE;
            end else if (req.write_level) begin
               phase_in = PH_TX_FALL;
            end
         end
         PH_TX_FALL: begin
            if (req.motor_on) begin
               result.aborted = 1'b1;
               result.tx_done = 1'b1;
               sense_in       = 1'b0;
               phase_in       = PH_IDLE;
            end else if (!req.write_level) begin
               sense_in     = |(shift_ff & tpsbl_pkg::MsbMask);
               shift_in     = {shift_ff[tpsbl_pkg::ByteWidth-2:0], 1'b0};
               bit_count_in = bit_count_ff + 1'b1;
               phase_in     = PH_TX_RISE;
            end
         end
         PH_TX_RISE: begin
            if (req.motor_on) begin
               // abort after the last bit counts as a normal end
               result.aborted = !all_bits;
               result.tx_done = 1'b1;
               sense_in       = 1'b0;
               phase_in       = PH_IDLE;
            end else if (req.write_level) begin
               phase_in = all_bits ? PH_TX_END : PH_TX_FALL;
            end
         end
         PH_TX_END: begin
            if (req.motor_on || !req.write_level) begin
               result.tx_done = 1'b1;
               sense_in       = 1'b0;
               phase_in       = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      result.sense_drive = sense_in;
      result.busy_res    = (phase_in != PH_IDLE);
   end

   // state registers, updated once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= '0;
         shift_ff       <= '0;
         delay_count_ff <= '0;
         sense_ff       <= 1'b1;
      end else if (accept) begin
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         shift_ff       <= shift_in;
         delay_count_ff <= delay_count_in;
         sense_ff       <= sense_in;
      end
   end

   // busy delay register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_delay_ff <= tpsbl_pkg::DelayReset;
      end else if (cfg_write) begin
         busy_delay_ff <= cfg_data;
      end
   end

endmodule
